// ----- sv/knn_graph_insert_macros.svh -----
// Assertion macros for the k-nearest-neighbor graph block.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef KNN_GRAPH_INSERT_MACROS_SVH
`define KNN_GRAPH_INSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked while out of reset.
`define KNN_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("knn assertion failed");
// Next-cycle implication, checked while out of reset.
`define KNN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("knn assertion failed");
`else
`define KNN_ASSERT(lbl, ante, cons)
`define KNN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/knn_pkg.sv -----
// Shared constants, command codes and list types for the k-nearest-neighbor graph block.
// No dependencies.
package knn_pkg;
	localparam int MAX_POINTS = 256;
	localparam int MAX_LIST   = 16;
	localparam int NODE_W     = 8;
	localparam int SLOT_W     = 4;
	localparam int CNT_W      = 5;
	localparam int DIST_W     = 34;
	localparam int COORD_W    = 16;
	localparam int HELD_W     = 9;

	// Command kinds carried by the kind field.
	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [NODE_W-1:0] idx;
		logic [DIST_W-1:0] sqd;
	} entry_t;

	// One node's neighbor list: count and entries sorted by distance.
	typedef struct packed {
		logic [CNT_W-1:0]               cnt;
		entry_t [MAX_LIST-1:0]          ent;
	} row_t;
endpackage

// ----- sv/knn_graph_insert.sv -----
// Top level of the incremental k-nearest-neighbor graph over 3D points.
// Depends on knn_pkg, knn_list_ins and knn_graph_insert_macros.svh.
//
// Channel   | Handshake            | Beat contents
// ----------+----------------------+---------------------------------------------
// command   | start, busy          | kind, pos_x, pos_y, pos_z, query_node, query_slot
// result    | done (one cycle)     | node_index, neighbour_count, neighbour_index,
//           |                      | neighbour_distance, entry_valid, rejected
// config    | cfg_we               | cfg_wdata (neighbor limit)
//
// An add visits every stored node in turn, each costing a point and list memory read,
// a difference stage, a square stage, a sum stage and a list update; it then writes the
// new node's list and raises done. A read raises done after a memory read and an output
// state. An add into a full store raises done in the next cycle, without raising busy.
// Reset clears the control state only; the memories need no clearing pass.
// Busy holds off new commands while one is in work; the result receiver cannot stall.
`include "knn_graph_insert_macros.svh"
module knn_graph_insert import knn_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cfg_we,
	input  logic [CNT_W-1:0]          cfg_wdata,
	input  logic                      kind,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic [NODE_W-1:0]         query_node,
	input  logic [SLOT_W-1:0]         query_slot,
	output logic                      done,
	output logic [NODE_W-1:0]         node_index,
	output logic [CNT_W-1:0]          neighbour_count,
	output logic [NODE_W-1:0]         neighbour_index,
	output logic [DIST_W-1:0]         neighbour_distance,
	output logic                      entry_valid,
	output logic                      rejected
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_DIFF = 3'd2;
	localparam logic [2:0] ST_SQ   = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_INS  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;
	localparam logic [2:0] ST_QOUT = 3'd7;

	logic [2:0]                state_q;
	logic [CNT_W-1:0]          cfg_q;
	logic [HELD_W-1:0]         held_q;
	logic [NODE_W-1:0]         addr_q;
	logic [NODE_W-1:0]         n_q;
	logic                      add_q;
	logic [SLOT_W-1:0]         slot_q;
	logic [3*COORD_W-1:0]      new_pos_q;
	row_t                      new_q;
	logic                      accept;
	logic [CNT_W-1:0]          limit;

	// Point store and list store, one row per node.
	logic [3*COORD_W-1:0]      pt_mem [MAX_POINTS];
	row_t                      row_mem [MAX_POINTS];
	logic [3*COORD_W-1:0]      pt_rd;
	row_t                      row_rd;
	logic                      row_we;
	logic [NODE_W-1:0]         row_waddr;
	row_t                      row_wdata;

	// Distance pipeline.
	logic [COORD_W-1:0]        mag_s1 [3];
	logic [2*COORD_W-1:0]      sq_s2 [3];
	logic [DIST_W-1:0]         d_s3;

	row_t                      node_row_nx;
	row_t                      new_row_nx;
	logic                      node_taken;
	logic                      new_taken;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Effective neighbor limit from the register.
	always_comb begin
		if (cfg_q == '0) begin
			limit = CNT_W'(1);
		end else if (cfg_q > CNT_W'(MAX_LIST)) begin
			limit = CNT_W'(MAX_LIST);
		end else begin
			limit = cfg_q;
		end
	end

	// Memories: the new point is written when an add is accepted with room, reads run every cycle.
	always_ff @(posedge clk) begin
		if (accept && kind == KIND_ADD && held_q < HELD_W'(MAX_POINTS)) begin
			pt_mem[held_q[NODE_W-1:0]] <= {pos_x, pos_y, pos_z};
		end
		pt_rd <= pt_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		row_rd <= row_mem[addr_q];
	end

	// Row write-back: visited node on update, new node at the end.
	always_comb begin
		row_we    = 1'b0;
		row_waddr = addr_q;
		row_wdata = node_row_nx;
		case (state_q)
			ST_INS: begin
				row_we = node_taken;
			end
			ST_FIN: begin
				row_we    = 1'b1;
				row_waddr = n_q;
				row_wdata = new_q;
			end
			default: begin
				row_we = 1'b0;
			end
		endcase
	end

	knn_list_ins u_node_ins (
		.row_in  (row_rd),
		.nb      (n_q),
		.new_sqd (d_s3),
		.limit   (limit),
		.row_out (node_row_nx),
		.taken   (node_taken)
	);

	knn_list_ins u_new_ins (
		.row_in  (new_q),
		.nb      (addr_q),
		.new_sqd (d_s3),
		.limit   (limit),
		.row_out (new_row_nx),
		.taken   (new_taken)
	);

	// Squared distance: magnitudes, squares, sum.
	always_ff @(posedge clk) begin
		logic signed [COORD_W:0] df;
		for (int k = 0; k < 3; k++) begin
			df = {pt_rd[k*COORD_W + COORD_W-1], pt_rd[k*COORD_W +: COORD_W]}
				- {new_pos_q[k*COORD_W + COORD_W-1], new_pos_q[k*COORD_W +: COORD_W]};
			mag_s1[k] <= df[COORD_W] ? COORD_W'(-df) : df[COORD_W-1:0];
			sq_s2[k]  <= mag_s1[k] * mag_s1[k];
		end
		d_s3 <= DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2]);
	end

	// New point's own list and coordinates.
	always_ff @(posedge clk) begin
		if (accept) begin
			new_pos_q   <= {pos_x, pos_y, pos_z};
			new_q.cnt   <= '0;
			slot_q      <= query_slot;
		end else if (state_q == ST_INS && node_taken && new_taken) begin
			new_q <= new_row_nx;
		end
	end

	// Control sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= ST_IDLE;
			cfg_q              <= CNT_W'(8);
			held_q             <= '0;
			addr_q             <= '0;
			n_q                <= '0;
			add_q              <= 1'b0;
			done               <= 1'b0;
			node_index         <= '0;
			neighbour_count    <= '0;
			neighbour_index    <= '0;
			neighbour_distance <= '0;
			entry_valid        <= 1'b0;
			rejected           <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						add_q <= (kind == KIND_ADD);
						if (kind != KIND_ADD) begin
							addr_q  <= query_node;
							n_q     <= query_node;
							state_q <= ST_RD;
						end else if (held_q >= HELD_W'(MAX_POINTS)) begin
							done               <= 1'b1;
							node_index         <= '0;
							neighbour_count    <= '0;
							neighbour_index    <= '0;
							neighbour_distance <= '0;
							entry_valid        <= 1'b0;
							rejected           <= 1'b1;
						end else begin
							addr_q  <= '0;
							n_q     <= held_q[NODE_W-1:0];
							state_q <= (held_q == '0) ? ST_FIN : ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= add_q ? ST_DIFF : ST_QOUT;
				end
				ST_DIFF: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_INS;
				end
				ST_INS: begin
					addr_q  <= addr_q + NODE_W'(1);
					state_q <= (addr_q + NODE_W'(1) == n_q) ? ST_FIN : ST_RD;
				end
				ST_FIN: begin
					held_q             <= held_q + HELD_W'(1);
					done               <= 1'b1;
					node_index         <= n_q;
					neighbour_count    <= new_q.cnt;
					neighbour_index    <= '0;
					neighbour_distance <= '0;
					entry_valid        <= 1'b0;
					rejected           <= 1'b0;
					state_q            <= ST_IDLE;
				end
				ST_QOUT: begin
					done               <= 1'b1;
					node_index         <= n_q;
					rejected           <= 1'b0;
					neighbour_index    <= '0;
					neighbour_distance <= '0;
					entry_valid        <= 1'b0;
					neighbour_count    <= '0;
					if ({1'b0, n_q} < held_q) begin
						neighbour_count <= row_rd.cnt;
						if ({1'b0, slot_q} < row_rd.cnt) begin
							neighbour_index    <= row_rd.ent[slot_q].idx;
							neighbour_distance <= row_rd.ent[slot_q].sqd;
							entry_valid        <= 1'b1;
						end
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencer and result register.
	`KNN_ASSERT(a_done_cause, done, $past(busy) || $past(start))
	`KNN_ASSERT(a_visit_range, state_q == ST_INS, addr_q < n_q)
	`KNN_ASSERT(a_new_cnt, busy && add_q, new_q.cnt <= CNT_W'(MAX_LIST))
	`KNN_ASSERT_NEXT(a_fin_done, state_q == ST_FIN, done && !busy && !rejected)
endmodule

// ----- sv/knn_list_ins.sv -----
// Sorted insertion of one neighbor into one neighbor list, all lanes at once.
// Depends on knn_pkg.
module knn_list_ins import knn_pkg::*; (
	input  row_t              row_in,
	input  logic [NODE_W-1:0] nb,
	input  logic [DIST_W-1:0] new_sqd,
	input  logic [CNT_W-1:0]  limit,
	output row_t              row_out,
	output logic              taken
);
	logic [MAX_LIST-1:0] ahead;
	logic [SLOT_W-1:0]   last;
	entry_t              ins;

	// Entries that stay ahead of the new one form a prefix of the list.
	always_comb begin
		for (int j = 0; j < MAX_LIST; j++) begin
			ahead[j] = (CNT_W'(j) < row_in.cnt) && (row_in.ent[j].sqd <= new_sqd);
		end
	end

	assign last      = SLOT_W'(row_in.cnt - CNT_W'(1));
	assign ins.idx   = nb;
	assign ins.sqd   = new_sqd;
	// A full list takes the entry only if its furthest one is strictly further.
	assign taken     = (row_in.cnt < limit) || !ahead[last];

	// Keep the prefix, place the new entry, shift the rest down one slot.
	always_comb begin
		row_out.cnt = (row_in.cnt < limit) ? row_in.cnt + CNT_W'(1) : row_in.cnt;
		row_out.ent[0] = ahead[0] ? row_in.ent[0] : ins;
		for (int j = 1; j < MAX_LIST; j++) begin
			if (ahead[j]) begin
				row_out.ent[j] = row_in.ent[j];
			end else if (ahead[j-1]) begin
				row_out.ent[j] = ins;
			end else begin
				row_out.ent[j] = row_in.ent[j-1];
			end
		end
	end
endmodule

// ----- tb/knn_graph_insert_test.sv -----
// Self-checking testbench for the incremental k-nearest-neighbor graph block.
// Predicts every result from its own copy of the graph; depends on knn_pkg and
// on the knn_graph_insert RTL.
`timescale 1ns / 1ps
module knn_graph_insert_test;
	import knn_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		bit                         kind;
		logic signed [COORD_W-1:0]  x, y, z;
		logic [NODE_W-1:0]          qnode;
		logic [SLOT_W-1:0]          qslot;
	} command_t;

	typedef struct {
		logic [NODE_W-1:0] node;
		logic [CNT_W-1:0]  cnt;
		logic [NODE_W-1:0] nb;
		logic [DIST_W-1:0] sqd;
		logic              valid;
		logic              rej;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic kind = 1'b0;
	logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [NODE_W-1:0] query_node = '0;
	logic [SLOT_W-1:0] query_slot = '0;
	logic done;
	logic [NODE_W-1:0] node_index;
	logic [CNT_W-1:0] neighbour_count;
	logic [NODE_W-1:0] neighbour_index;
	logic [DIST_W-1:0] neighbour_distance;
	logic entry_valid;
	logic rejected;

	command_t pending_cmds[$];
	outcome_t expected_outcomes[$];
	bit beat_taken = 1'b0;
	bit calm = 1'b0;
	int mismatches = 0;
	int cycles = 0;

	// Generator-side view of the stored points, used to build ties.
	int adds_queued = 0;
	logic signed [COORD_W-1:0] gen_x[MAX_POINTS], gen_y[MAX_POINTS], gen_z[MAX_POINTS];

	// Predicted graph state.
	int pt_x[MAX_POINTS], pt_y[MAX_POINTS], pt_z[MAX_POINTS];
	int held;
	int nb_count[MAX_POINTS];
	int nb_node[MAX_POINTS*MAX_LIST];
	longint nb_dist[MAX_POINTS*MAX_LIST];
	logic [CNT_W-1:0] max_nb;

	knn_graph_insert u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic longint sq_gap(int a, int b);
		longint d;
		d = longint'(a) - longint'(b);
		return d * d;
	endfunction

	// Sorted insertion; equal distances go after older entries.
	function automatic bit link_into(int node, int nb, longint d, int lim);
		int base, cnt, p, j;
		base = node * MAX_LIST;
		cnt = nb_count[node];
		p = 0;
		while (p < cnt && !(d < nb_dist[base + p])) p++;
		if (cnt < lim) begin
			for (j = cnt; j > p; j--) begin
				nb_node[base + j] = nb_node[base + j - 1];
				nb_dist[base + j] = nb_dist[base + j - 1];
			end
			nb_count[node] = cnt + 1;
		end else begin
			if (p >= cnt) return 1'b0;
			for (j = cnt - 1; j > p; j--) begin
				nb_node[base + j] = nb_node[base + j - 1];
				nb_dist[base + j] = nb_dist[base + j - 1];
			end
		end
		nb_node[base + p] = nb;
		nb_dist[base + p] = d;
		return 1'b1;
	endfunction

	function automatic outcome_t apply_command(command_t c);
		outcome_t o;
		int lim, n, i, q, s;
		longint d;
		o = '{default: '0};
		if (c.kind == KIND_ADD) begin
			if (held >= MAX_POINTS) begin
				o.rej = 1'b1;
			end else begin
				n = held;
				lim = (max_nb < 1) ? 1 : ((max_nb > MAX_LIST) ? MAX_LIST : int'(max_nb));
				pt_x[n] = c.x;
				pt_y[n] = c.y;
				pt_z[n] = c.z;
				nb_count[n] = 0;
				for (i = 0; i < n; i++) begin
					d = sq_gap(pt_x[i], pt_x[n]) + sq_gap(pt_y[i], pt_y[n]) +
						sq_gap(pt_z[i], pt_z[n]);
					if (link_into(i, n, d, lim)) void'(link_into(n, i, d, lim));
				end
				held = n + 1;
				o.node = NODE_W'(n);
				o.cnt = CNT_W'(nb_count[n]);
			end
		end else begin
			q = c.qnode;
			s = c.qslot;
			o.node = c.qnode;
			if (q < held) begin
				o.cnt = CNT_W'(nb_count[q]);
				if (s < nb_count[q]) begin
					o.nb = NODE_W'(nb_node[q*MAX_LIST + s]);
					o.sqd = DIST_W'(nb_dist[q*MAX_LIST + s]);
					o.valid = 1'b1;
				end
			end
		end
		return o;
	endfunction

	// Driver: a beat stays on the ports until it is taken.
	always @(negedge clk) begin
		command_t c;
		logic nxt;
		if (arst_n && !(start && !beat_taken)) begin
			nxt = 1'b0;
			if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 17)) begin
				c = pending_cmds.pop_front();
				kind <= c.kind;
				pos_x <= c.x;
				pos_y <= c.y;
				pos_z <= c.z;
				query_node <= c.qnode;
				query_slot <= c.qslot;
				nxt = 1'b1;
			end
			start <= nxt;
		end
	end

	// Monitor: check results, track register writes, predict accepted beats.
	always @(posedge clk) begin
		outcome_t e;
		command_t c;
		beat_taken <= arst_n && start && !busy;
		if (!arst_n) begin
			max_nb = 5'd8;
			held = 0;
			for (int i = 0; i < MAX_POINTS; i++) nb_count[i] = 0;
		end else begin
			if (done) begin
				if (expected_outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat for node %0d", node_index);
				end else begin
					e = expected_outcomes.pop_front();
					if (node_index !== e.node || neighbour_count !== e.cnt ||
						neighbour_index !== e.nb || neighbour_distance !== e.sqd ||
						entry_valid !== e.valid || rejected !== e.rej) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch: expected node %0d cnt %0d nb %0d dist %0d v %0d r %0d",
								e.node, e.cnt, e.nb, e.sqd, e.valid, e.rej);
							$display("          got node %0d cnt %0d nb %0d dist %0d v %0d r %0d",
								node_index, neighbour_count, neighbour_index,
								neighbour_distance, entry_valid, rejected);
						end
					end
				end
			end
			if (cfg_we) max_nb = cfg_wdata;
			if (start && !busy) begin
				c.kind = kind;
				c.x = pos_x;
				c.y = pos_y;
				c.z = pos_z;
				c.qnode = query_node;
				c.qslot = query_slot;
				expected_outcomes.push_back(apply_command(c));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic queue_add(logic signed [COORD_W-1:0] x, y, z);
		command_t c;
		c = '{KIND_ADD, x, y, z, NODE_W'($urandom), SLOT_W'($urandom)};
		if (adds_queued < MAX_POINTS) begin
			gen_x[adds_queued] = x;
			gen_y[adds_queued] = y;
			gen_z[adds_queued] = z;
			adds_queued++;
		end
		pending_cmds.push_back(c);
	endtask

	task automatic queue_read(int node, int slot);
		command_t c;
		c = '{KIND_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
			node[NODE_W-1:0], slot[SLOT_W-1:0]};
		pending_cmds.push_back(c);
	endtask

	// Waits until every beat has gone in and every result has come back.
	task automatic drain();
		do @(negedge clk);
		while (pending_cmds.size() > 0 || expected_outcomes.size() > 0 || start || busy);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(logic [CNT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_random(int count);
		int r, k;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 30) begin
				r = $urandom_range(99);
				if (r < 25) begin
					queue_add(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
				end else if (r < 75 || adds_queued == 0) begin
					queue_add(COORD_W'(int'($urandom_range(200)) - 100),
						COORD_W'(int'($urandom_range(200)) - 100),
						COORD_W'(int'($urandom_range(200)) - 100));
				end else begin
					k = $urandom_range((adds_queued > MAX_POINTS ? MAX_POINTS : adds_queued) - 1);
					queue_add(gen_x[k], gen_y[k], gen_z[k]);
				end
			end else if ($urandom_range(99) < 85) begin
				queue_read($urandom_range(adds_queued + 2 > 255 ? 255 : adds_queued + 2),
					$urandom_range(15));
			end else begin
				queue_read($urandom_range(255), $urandom_range(15));
			end
		end
	endtask

	initial begin
		logic [CNT_W-1:0] limits[9];
		limits = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd5, 5'd12, 5'd2, 5'd8, 5'd0};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme coordinates, ties, unstored nodes and slots.
		queue_read(255, 15);
		queue_add(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		queue_add(16'sh8000, 16'sh8000, 16'sh8000);
		queue_add(0, 0, 0);
		queue_add(0, 0, 0);
		queue_add(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		queue_add(16'sh8000, 16'sh7FFF, 16'sh8000);
		queue_add(1, -1, 1);
		for (int s = 0; s < 4; s++) queue_read(0, s);
		queue_read(0, 15);
		queue_read(6, 0);
		queue_read(7, 0);
		queue_read(3, 1);
		queue_read(2, 0);
		drain();

		for (int p = 0; p < 9; p++) begin
			set_limit(p == 8 ? 5'($urandom) : limits[p]);
			calm = (p == 3);
			queue_random(128);
			drain();
		end

		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+sv
sv/knn_pkg.sv
sv/knn_list_ins.sv
sv/knn_graph_insert.sv
tb/knn_graph_insert_test.sv
